// ===== hdl/flr_pkg.sv =====
// Shared constants, codes and control structs for the failure lockout table.
// Used by the interfaces, the controller, the datapath and the checker.
`timescale 1ns / 1ps
`default_nettype none

package flr_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int KEY_BITS    = 64;
  localparam int TIME_BITS   = 48;
  localparam int IDX_BITS    = $clog2(TABLE_DEPTH);
  localparam int CNT_BITS    = 5;
  localparam int FAIL_BITS   = 8;
  localparam int TICK_BITS   = 32;
  localparam int CFG_IDX_BITS = 2;
  localparam int CFG_DATA_BITS = 32;

  localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(TABLE_DEPTH - 1);

  localparam logic [1:0] OPC_QUERY   = 2'd0;
  localparam logic [1:0] OPC_FAILURE = 2'd1;
  localparam logic [1:0] OPC_SUCCESS = 2'd2;

  localparam logic [CFG_IDX_BITS-1:0] REG_SOURCE_LIMIT  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_FAILURE_LIMIT = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_TICKS  = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_BLOCK_TICKS   = 2'd3;

  typedef logic [IDX_BITS-1:0] idx_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_FIND,
    OP_ALLOW,
    OP_INIT,
    OP_LOAD,
    OP_REFRESH,
    OP_QWRITE,
    OP_BUMP,
    OP_FWRITE,
    OP_SUCC,
    OP_MIN,
    OP_EVICT,
    OP_PLACE,
    OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    idx_t   idx;
  } flr_cmd_t;

  typedef struct packed {
    logic       found;
    logic       over;
    logic       extra;
    logic       present;
    logic [1:0] opcode;
    logic       out_busy;
  } flr_status_t;

endpackage

`default_nettype wire

// ===== hdl/flr_if.sv =====
// Channel interfaces: request items, result items and configuration writes.
// Depends on flr_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface flr_req_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    opcode;
  logic                          key_present;
  logic [flr_pkg::KEY_BITS-1:0]  source_key;
  logic [flr_pkg::TIME_BITS-1:0] now_time;

  modport source(output valid, opcode, key_present, source_key, now_time, input ready);
  modport sink(input valid, opcode, key_present, source_key, now_time, output ready);
endinterface

interface flr_rsp_if;
  logic                         valid;
  logic                         ready;
  logic                         allowed;
  logic [flr_pkg::CNT_BITS-1:0] tracked_count;

  modport source(output valid, allowed, tracked_count, input ready);
  modport sink(input valid, allowed, tracked_count, output ready);
endinterface

interface flr_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [flr_pkg::CFG_IDX_BITS-1:0]  index;
  logic [flr_pkg::CFG_DATA_BITS-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hdl/flr_ctrl.sv =====
// Sequencer for the lockout table: steps the key search, update and eviction scans.
// Depends on flr_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module flr_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  flr_pkg::flr_status_t status,
  output flr_pkg::flr_cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_FIND,
    S_DISPATCH,
    S_LOAD,
    S_REFRESH,
    S_QWRITE,
    S_BUMP,
    S_FWRITE,
    S_TCHECK,
    S_TSCAN,
    S_EVICT,
    S_PLACE,
    S_DONE
  } state_t;

  state_t        state;
  flr_pkg::idx_t idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            state <= S_FIND;
            idx   <= '0;
          end
        end
        S_FIND: begin
          if (idx == flr_pkg::LAST_IDX) begin
            idx   <= '0;
            state <= S_DISPATCH;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_DISPATCH: begin
          if (!status.present) begin
            state <= S_DONE;
          end else begin
            case (status.opcode)
              flr_pkg::OPC_QUERY:   state <= status.found ? S_LOAD : S_DONE;
              flr_pkg::OPC_FAILURE: state <= status.found ? S_LOAD : S_BUMP;
              default:              state <= S_DONE;
            endcase
          end
        end
        S_LOAD:    state <= S_REFRESH;
        S_REFRESH: state <= (status.opcode == flr_pkg::OPC_QUERY) ? S_QWRITE : S_BUMP;
        S_QWRITE:  state <= S_DONE;
        S_BUMP:    state <= S_FWRITE;
        S_FWRITE:  state <= S_TCHECK;
        S_TCHECK: begin
          if (status.over) begin
            idx   <= '0;
            state <= S_TSCAN;
          end else if (status.extra) begin
            state <= S_PLACE;
          end else begin
            state <= S_DONE;
          end
        end
        S_TSCAN: begin
          if (idx == flr_pkg::LAST_IDX) begin
            idx   <= '0;
            state <= S_EVICT;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_EVICT: state <= S_TCHECK;
        S_PLACE: state <= S_DONE;
        S_DONE: begin
          if (!status.out_busy) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign req_ready = (state == S_IDLE);

  always_comb begin
    cmd.idx = idx;
    cmd.op  = flr_pkg::OP_NONE;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.op = flr_pkg::OP_CAPTURE;
        end
      end
      S_FIND: cmd.op = flr_pkg::OP_FIND;
      S_DISPATCH: begin
        if (status.present) begin
          case (status.opcode)
            flr_pkg::OPC_QUERY: begin
              if (!status.found) begin
                cmd.op = flr_pkg::OP_ALLOW;
              end
            end
            flr_pkg::OPC_FAILURE: begin
              if (!status.found) begin
                cmd.op = flr_pkg::OP_INIT;
              end
            end
            flr_pkg::OPC_SUCCESS: cmd.op = flr_pkg::OP_SUCC;
            default: cmd.op = flr_pkg::OP_NONE;
          endcase
        end
      end
      S_LOAD:    cmd.op = flr_pkg::OP_LOAD;
      S_REFRESH: cmd.op = flr_pkg::OP_REFRESH;
      S_QWRITE:  cmd.op = flr_pkg::OP_QWRITE;
      S_BUMP:    cmd.op = flr_pkg::OP_BUMP;
      S_FWRITE:  cmd.op = flr_pkg::OP_FWRITE;
      S_TSCAN:   cmd.op = flr_pkg::OP_MIN;
      S_EVICT:   cmd.op = flr_pkg::OP_EVICT;
      S_PLACE:   cmd.op = flr_pkg::OP_PLACE;
      S_DONE: begin
        if (!status.out_busy) begin
          cmd.op = flr_pkg::OP_EMIT;
        end
      end
      default: cmd.op = flr_pkg::OP_NONE;
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/flr_datapath.sv =====
// Datapath of the lockout table: slot storage, configuration registers, window and
// deadline arithmetic, least recently seen search and the result register. Uses flr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module flr_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  flr_pkg::flr_cmd_t                 cmd,
  output flr_pkg::flr_status_t              status,
  input  logic [1:0]                        req_opcode,
  input  logic                              req_key_present,
  input  logic [flr_pkg::KEY_BITS-1:0]      req_source_key,
  input  logic [flr_pkg::TIME_BITS-1:0]     req_now_time,
  input  logic                              cfg_valid,
  input  logic [flr_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [flr_pkg::CFG_DATA_BITS-1:0] cfg_data,
  input  logic                              rsp_ready,
  output logic                              rsp_valid,
  output logic                              rsp_allowed,
  output logic [flr_pkg::CNT_BITS-1:0]      rsp_tracked_count
);

  localparam int TB = flr_pkg::TIME_BITS;

  logic [flr_pkg::CNT_BITS-1:0]  source_limit;
  logic [flr_pkg::FAIL_BITS-1:0] failure_limit;
  logic [flr_pkg::TICK_BITS-1:0] window_ticks;
  logic [flr_pkg::TICK_BITS-1:0] block_ticks;

  logic                         slot_valid [flr_pkg::TABLE_DEPTH];
  logic [flr_pkg::KEY_BITS-1:0] slot_key [flr_pkg::TABLE_DEPTH];
  logic [flr_pkg::FAIL_BITS-1:0] slot_failures [flr_pkg::TABLE_DEPTH];
  logic [TB-1:0]                slot_window_start [flr_pkg::TABLE_DEPTH];
  logic [TB-1:0]                slot_blocked_until [flr_pkg::TABLE_DEPTH];
  logic [TB-1:0]                slot_last_seen [flr_pkg::TABLE_DEPTH];
  logic [flr_pkg::CNT_BITS-1:0] valid_count;

  logic [1:0]                    cur_op;
  logic                          cur_present;
  logic [flr_pkg::KEY_BITS-1:0]  cur_key;
  logic [TB-1:0]                 now_t;
  logic                          found;
  flr_pkg::idx_t                 found_idx;
  logic                          have_min;
  logic [TB-1:0]                 min_ls;
  flr_pkg::idx_t                 min_idx;
  logic                          extra_valid;
  logic [flr_pkg::FAIL_BITS-1:0] w_fail;
  logic [TB-1:0]                 w_ws;
  logic [TB-1:0]                 w_bu;
  logic                          blk;
  logic                          allowed;

  flr_pkg::idx_t                 rd_ptr;
  logic [flr_pkg::FAIL_BITS-1:0] rd_fail;
  logic [TB-1:0]                 rd_ws;
  logic [TB-1:0]                 rd_bu;
  logic [TB-1:0]                 rd_ls;
  logic                          free_any;
  flr_pkg::idx_t                 free_idx;
  logic [flr_pkg::CNT_BITS-1:0]  lim_eff;
  logic [flr_pkg::FAIL_BITS-1:0] flim;
  logic [flr_pkg::TICK_BITS-1:0] wt;
  logic [flr_pkg::TICK_BITS-1:0] bt;
  logic [TB-1:0]                 age;
  logic                          expired;
  logic                          blocked_now;
  logic                          is_query;
  logic [flr_pkg::FAIL_BITS-1:0] fail_inc;
  logic                          hit;
  logic [TB:0]                   dl_sum;
  logic [TB-1:0]                 deadline;
  logic                          evict_extra;
  logic                          wr_en;
  flr_pkg::idx_t                 wr_idx;

  always_comb begin
    if (cmd.op == flr_pkg::OP_FIND || cmd.op == flr_pkg::OP_MIN) begin
      rd_ptr = cmd.idx;
    end else begin
      rd_ptr = found_idx;
    end
  end

  assign rd_fail = slot_failures[rd_ptr];
  assign rd_ws   = slot_window_start[rd_ptr];
  assign rd_bu   = slot_blocked_until[rd_ptr];
  assign rd_ls   = slot_last_seen[rd_ptr];

  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = flr_pkg::TABLE_DEPTH - 1; i >= 0; i--) begin
      if (!slot_valid[i]) begin
        free_any = 1'b1;
        free_idx = flr_pkg::IDX_BITS'(i);
      end
    end
  end

  always_comb begin
    if (source_limit == '0) begin
      lim_eff = flr_pkg::CNT_BITS'(1);
    end else if (source_limit > flr_pkg::CNT_BITS'(flr_pkg::TABLE_DEPTH)) begin
      lim_eff = flr_pkg::CNT_BITS'(flr_pkg::TABLE_DEPTH);
    end else begin
      lim_eff = source_limit;
    end
  end

  assign flim = (failure_limit == '0) ? flr_pkg::FAIL_BITS'(1) : failure_limit;
  assign wt   = (window_ticks == '0) ? flr_pkg::TICK_BITS'(1) : window_ticks;
  assign bt   = (block_ticks == '0) ? flr_pkg::TICK_BITS'(1) : block_ticks;

  assign is_query    = (cur_op == flr_pkg::OPC_QUERY);
  assign age         = now_t - w_ws;
  assign expired     = (now_t >= w_ws) && (age >= TB'(wt));
  assign blocked_now = (w_bu > now_t);

  assign fail_inc = (w_fail < flim) ? w_fail + 1'b1 : w_fail;
  assign hit      = (fail_inc >= flim);
  assign dl_sum   = {1'b0, now_t} + (TB + 1)'(bt);
  assign deadline = dl_sum[TB] ? {TB{1'b1}} : dl_sum[TB-1:0];

  assign evict_extra = extra_valid && (!have_min || now_t < min_ls);

  always_comb begin
    wr_en  = 1'b0;
    wr_idx = found_idx;
    case (cmd.op)
      flr_pkg::OP_QWRITE: wr_en = 1'b1;
      flr_pkg::OP_FWRITE: begin
        wr_en  = found || free_any;
        wr_idx = found ? found_idx : free_idx;
      end
      flr_pkg::OP_PLACE: begin
        wr_en  = 1'b1;
        wr_idx = free_idx;
      end
      default: wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_key[wr_idx]           <= cur_key;
      slot_failures[wr_idx]      <= w_fail;
      slot_window_start[wr_idx]  <= w_ws;
      slot_blocked_until[wr_idx] <= w_bu;
      slot_last_seen[wr_idx]     <= now_t;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == flr_pkg::OP_CAPTURE) begin
      cur_op      <= req_opcode;
      cur_present <= req_key_present;
      cur_key     <= req_source_key;
      now_t       <= req_now_time;
    end
    case (cmd.op)
      flr_pkg::OP_LOAD: begin
        w_fail <= rd_fail;
        w_ws   <= rd_ws;
        w_bu   <= rd_bu;
      end
      flr_pkg::OP_INIT: begin
        w_fail <= '0;
        w_ws   <= now_t;
        w_bu   <= '0;
      end
      flr_pkg::OP_REFRESH: begin
        if (!(is_query && blocked_now)) begin
          if (expired) begin
            w_fail <= '0;
            w_ws   <= now_t;
            w_bu   <= '0;
          end else if (!blocked_now) begin
            w_bu <= '0;
          end
        end
      end
      flr_pkg::OP_BUMP: begin
        w_fail <= fail_inc;
        if (hit) begin
          w_bu <= deadline;
        end
      end
      flr_pkg::OP_MIN: begin
        if (slot_valid[cmd.idx] && (cmd.idx == '0 || !have_min || rd_ls < min_ls)) begin
          min_ls  <= rd_ls;
          min_idx <= cmd.idx;
        end
      end
      default: begin
      end
    endcase
    if (cmd.op == flr_pkg::OP_EMIT) begin
      rsp_allowed       <= allowed;
      rsp_tracked_count <= valid_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      source_limit  <= flr_pkg::CNT_BITS'(16);
      failure_limit <= flr_pkg::FAIL_BITS'(5);
      window_ticks  <= flr_pkg::TICK_BITS'(60);
      block_ticks   <= flr_pkg::TICK_BITS'(300);
    end else if (cfg_valid) begin
      case (cfg_index)
        flr_pkg::REG_SOURCE_LIMIT:  source_limit  <= cfg_data[flr_pkg::CNT_BITS-1:0];
        flr_pkg::REG_FAILURE_LIMIT: failure_limit <= cfg_data[flr_pkg::FAIL_BITS-1:0];
        flr_pkg::REG_WINDOW_TICKS:  window_ticks  <= cfg_data[flr_pkg::TICK_BITS-1:0];
        flr_pkg::REG_BLOCK_TICKS:   block_ticks   <= cfg_data[flr_pkg::TICK_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < flr_pkg::TABLE_DEPTH; i++) begin
        slot_valid[i] <= 1'b0;
      end
      valid_count <= '0;
      found       <= 1'b0;
      found_idx   <= '0;
      have_min    <= 1'b0;
      extra_valid <= 1'b0;
      blk         <= 1'b0;
      allowed     <= 1'b0;
      rsp_valid   <= 1'b0;
    end else begin
      if (cmd.op == flr_pkg::OP_EMIT) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (cmd.op)
        flr_pkg::OP_CAPTURE: begin
          found   <= 1'b0;
          blk     <= 1'b0;
          allowed <= 1'b0;
        end
        flr_pkg::OP_FIND: begin
          if (slot_valid[cmd.idx] && slot_key[cmd.idx] == cur_key && !found) begin
            found     <= 1'b1;
            found_idx <= cmd.idx;
          end
        end
        flr_pkg::OP_ALLOW: allowed <= 1'b1;
        flr_pkg::OP_REFRESH: blk <= is_query && blocked_now;
        flr_pkg::OP_QWRITE: allowed <= !blk && (w_fail < flim);
        flr_pkg::OP_FWRITE: begin
          if (!found) begin
            valid_count <= valid_count + 1'b1;
            if (free_any) begin
              slot_valid[free_idx] <= 1'b1;
            end else begin
              extra_valid <= 1'b1;
            end
          end
        end
        flr_pkg::OP_SUCC: begin
          if (found) begin
            slot_valid[found_idx] <= 1'b0;
            valid_count           <= valid_count - 1'b1;
          end
        end
        flr_pkg::OP_MIN: begin
          if (slot_valid[cmd.idx] && (cmd.idx == '0 || !have_min || rd_ls < min_ls)) begin
            have_min <= 1'b1;
          end else if (cmd.idx == '0) begin
            have_min <= 1'b0;
          end
        end
        flr_pkg::OP_EVICT: begin
          if (evict_extra) begin
            extra_valid <= 1'b0;
            valid_count <= valid_count - 1'b1;
          end else if (have_min) begin
            slot_valid[min_idx] <= 1'b0;
            valid_count         <= valid_count - 1'b1;
          end
        end
        flr_pkg::OP_PLACE: begin
          slot_valid[free_idx] <= 1'b1;
          extra_valid          <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  assign status.found    = found;
  assign status.over     = (valid_count > lim_eff);
  assign status.extra    = extra_valid;
  assign status.present  = cur_present;
  assign status.opcode   = cur_op;
  assign status.out_busy = rsp_valid && !rsp_ready;

endmodule

`default_nettype wire

// ===== hdl/failure_lockout_rate_limiter.sv =====
// Top level of the per-source failure lockout table.
// Joins flr_ctrl and flr_datapath; uses flr_pkg and the channels in flr_if.
//
// Usage:
//   req carries one item: opcode (query, failure, success), key_present, source_key
//   and now_time. rsp returns one item per request: allowed and tracked_count.
//   cfg writes the source limit, failure limit, window length and block length by
//   index; it is always ready and should be written only while no item is in work.
// Sequence:
//   Every item first walks all 16 slots to find its key, one slot per cycle. Then an
//   empty key, an unknown key's query, a success or an unused opcode goes to the result;
//   a known key's query loads, refreshes and writes back its entry; a failure loads and
//   refreshes a known entry or starts a new one, counts the failure, writes the entry
//   and checks the source limit. Each eviction a failure causes adds a scan of all slots
//   for the least recently seen entry and an eviction step, and a source entered into a
//   full table adds a step that moves it into the freed slot. One item is in work at a
//   time: the next is accepted only once the previous result has been loaded.
// Reset and stalls:
//   Reset empties the table and restores the register defaults. The result waits in
//   an output register; the next item is accepted while it waits, but that item's
//   own result is held back until the previous one has been taken.
`timescale 1ns / 1ps
`default_nettype none

module failure_lockout_rate_limiter (
  input logic       clk,
  input logic       rst,
  flr_req_if.sink   req,
  flr_rsp_if.source rsp,
  flr_cfg_if.sink   cfg
);

  flr_pkg::flr_cmd_t    cmd;
  flr_pkg::flr_status_t status;

  assign cfg.ready = 1'b1;

  flr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .status    (status),
    .cmd       (cmd)
  );

  flr_datapath u_datapath (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .status            (status),
    .req_opcode        (req.opcode),
    .req_key_present   (req.key_present),
    .req_source_key    (req.source_key),
    .req_now_time      (req.now_time),
    .cfg_valid         (cfg.valid),
    .cfg_index         (cfg.index),
    .cfg_data          (cfg.data),
    .rsp_ready         (rsp.ready),
    .rsp_valid         (rsp.valid),
    .rsp_allowed       (rsp.allowed),
    .rsp_tracked_count (rsp.tracked_count)
  );

endmodule

`default_nettype wire

// ===== hdl/flr_checker.sv =====
// Port-level checks for failure_lockout_rate_limiter, attached with bind.
// Depends on flr_pkg for the table depth and count width.
`timescale 1ns / 1ps
`default_nettype none

module flr_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         req_valid,
  input logic                         req_ready,
  input logic                         rsp_valid,
  input logic                         rsp_ready,
  input logic                         rsp_allowed,
  input logic [flr_pkg::CNT_BITS-1:0] rsp_tracked_count
);

  logic [1:0] pending;
  logic       req_fire;
  logic       rsp_fire;

  assign req_fire = req_valid && req_ready;
  assign rsp_fire = rsp_valid && rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (req_fire && !rsp_fire) begin
      pending <= pending + 1'b1;
    end else if (rsp_fire && !req_fire) begin
      pending <= pending - 1'b1;
    end
  end

  a_reset_clears_result: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid after reset");

  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_tracked_count <= flr_pkg::CNT_BITS'(flr_pkg::TABLE_DEPTH))
    else $error("tracked count above table depth");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_allowed)
      && $stable(rsp_tracked_count))
    else $error("stalled result changed");

  a_one_item_in_work: assert property (@(posedge clk) disable iff (rst)
    req_fire |=> !req_ready)
    else $error("new item accepted during work");

  a_no_spurious_result: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> pending != 2'd0)
    else $error("result without an outstanding item");

endmodule

bind failure_lockout_rate_limiter flr_checker u_flr_checker (
  .clk               (clk),
  .rst               (rst),
  .req_valid         (req.valid),
  .req_ready         (req.ready),
  .rsp_valid         (rsp.valid),
  .rsp_ready         (rsp.ready),
  .rsp_allowed       (rsp.allowed),
  .rsp_tracked_count (rsp.tracked_count)
);

`default_nettype wire

// ===== tb/sv/failure_lockout_rate_limiter_test.sv =====
// Self-checking testbench for the failure lockout table: directed rules, then random traffic.
// Predicts each verdict with its own copy of the table and compares it with the rsp channel.
// Depends on flr_pkg, the channel interfaces in flr_if and the failure_lockout_rate_limiter top.
`timescale 1ns / 1ps

module failure_lockout_rate_limiter_test;

  localparam logic [1:0] OPC_UNUSED = 2'd3;
  localparam int EXTRA_SLOT = flr_pkg::TABLE_DEPTH;
  localparam int QUIET_LIMIT = 5000;
  localparam int HOLD_OFF_CYCLES = 250;
  localparam int TAIL_CYCLES = 64;
  localparam logic [flr_pkg::TIME_BITS-1:0] TIME_MAX = '1;
  localparam logic [flr_pkg::KEY_BITS-1:0] KEY_ZERO = '0;
  localparam logic [flr_pkg::KEY_BITS-1:0] KEY_ONES = '1;

  typedef struct packed {
    logic                         allowed;
    logic [flr_pkg::CNT_BITS-1:0] tracked;
  } lockout_verdict_t;

  logic clk;
  logic rst;

  flr_req_if req_ch ();
  flr_rsp_if rsp_ch ();
  flr_cfg_if cfg_ch ();

  failure_lockout_rate_limiter u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  // Shadow copy of the source table; the slot above the last one holds a new entry until trim.
  bit                            t_valid [0:flr_pkg::TABLE_DEPTH];
  logic [flr_pkg::KEY_BITS-1:0]  t_key   [0:flr_pkg::TABLE_DEPTH];
  int unsigned                   t_fails [0:flr_pkg::TABLE_DEPTH];
  logic [flr_pkg::TIME_BITS-1:0] t_start [0:flr_pkg::TABLE_DEPTH];
  logic [flr_pkg::TIME_BITS-1:0] t_until [0:flr_pkg::TABLE_DEPTH];
  logic [flr_pkg::TIME_BITS-1:0] t_seen  [0:flr_pkg::TABLE_DEPTH];
  int unsigned                   t_count;

  logic [flr_pkg::CNT_BITS-1:0]  lim_sources;
  logic [flr_pkg::FAIL_BITS-1:0] lim_failures;
  logic [flr_pkg::TICK_BITS-1:0] win_len;
  logic [flr_pkg::TICK_BITS-1:0] block_len;

  lockout_verdict_t              pending_verdicts [$];
  logic [flr_pkg::KEY_BITS-1:0]  key_pool [$];
  logic [flr_pkg::TIME_BITS-1:0] tick_now;

  int send_idle_pct;
  int rsp_stall_pct;
  int hold_off_request;
  int hold_left;
  int mismatch_count;
  int requests_sent;
  int results_checked;
  int settings_applied;
  int evictions;
  int refusals;
  int saturations;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic void clear_model();
    for (int i = 0; i <= flr_pkg::TABLE_DEPTH; i++) begin
      t_valid[i] = 1'b0;
      t_key[i]   = '0;
      t_fails[i] = 0;
      t_start[i] = '0;
      t_until[i] = '0;
      t_seen[i]  = '0;
    end
    t_count      = 0;
    lim_sources  = 5'd16;
    lim_failures = 8'd5;
    win_len      = 32'd60;
    block_len    = 32'd300;
  endfunction

  function automatic int find_entry(input logic [flr_pkg::KEY_BITS-1:0] key);
    for (int i = 0; i < flr_pkg::TABLE_DEPTH; i++)
      if (t_valid[i] && t_key[i] == key) return i;
    return -1;
  endfunction

  function automatic void refresh_entry(input int s, input logic [flr_pkg::TIME_BITS-1:0] now);
    logic [63:0] span;
    span = (win_len == 0) ? 64'd1 : 64'(win_len);
    if (now >= t_start[s] && 64'(now - t_start[s]) >= span) begin
      t_fails[s] = 0;
      t_start[s] = now;
      t_until[s] = '0;
    end
    if (t_until[s] <= now) t_until[s] = '0;
  endfunction

  function automatic void trim_table();
    int unsigned lim;
    int oldest;
    lim = (lim_sources == 0) ? 1 :
          ((lim_sources > flr_pkg::TABLE_DEPTH) ? flr_pkg::TABLE_DEPTH : lim_sources);
    while (t_count > lim) begin
      oldest = -1;
      for (int i = 0; i <= EXTRA_SLOT; i++)
        if (t_valid[i] && (oldest < 0 || t_seen[i] < t_seen[oldest])) oldest = i;
      if (oldest < 0) break;
      t_valid[oldest] = 1'b0;
      t_count--;
      evictions++;
    end
    if (t_valid[EXTRA_SLOT]) begin
      for (int i = 0; i < flr_pkg::TABLE_DEPTH; i++) begin
        if (!t_valid[i]) begin
          t_valid[i] = 1'b1;
          t_key[i]   = t_key[EXTRA_SLOT];
          t_fails[i] = t_fails[EXTRA_SLOT];
          t_start[i] = t_start[EXTRA_SLOT];
          t_until[i] = t_until[EXTRA_SLOT];
          t_seen[i]  = t_seen[EXTRA_SLOT];
          break;
        end
      end
      t_valid[EXTRA_SLOT] = 1'b0;
    end
  endfunction

  function automatic lockout_verdict_t predict_verdict(
      input logic [1:0] op,
      input logic present,
      input logic [flr_pkg::KEY_BITS-1:0] key,
      input logic [flr_pkg::TIME_BITS-1:0] now);
    lockout_verdict_t v;
    int s;
    int unsigned flim;
    logic [63:0] blk;
    flim = (lim_failures == 0) ? 1 : lim_failures;
    v.allowed = 1'b0;
    if (present && op == flr_pkg::OPC_QUERY) begin
      s = find_entry(key);
      if (s < 0) begin
        v.allowed = 1'b1;
      end else begin
        t_seen[s] = now;
        if (t_until[s] > now) begin
          refusals++;
        end else begin
          refresh_entry(s, now);
          v.allowed = (t_fails[s] < flim);
        end
      end
    end else if (present && op == flr_pkg::OPC_FAILURE) begin
      s = find_entry(key);
      if (s >= 0) begin
        refresh_entry(s, now);
      end else begin
        s = EXTRA_SLOT;
        for (int i = 0; i < flr_pkg::TABLE_DEPTH; i++) begin
          if (!t_valid[i]) begin
            s = i;
            break;
          end
        end
        t_valid[s] = 1'b1;
        t_key[s]   = key;
        t_fails[s] = 0;
        t_start[s] = now;
        t_until[s] = '0;
        t_count++;
      end
      t_seen[s] = now;
      if (t_fails[s] < flim) t_fails[s]++;
      if (t_fails[s] >= flim) begin
        blk = (block_len == 0) ? 64'd1 : 64'(block_len);
        if (blk > 64'(TIME_MAX - now)) begin
          t_until[s] = TIME_MAX;
          saturations++;
        end else begin
          t_until[s] = now + blk[flr_pkg::TIME_BITS-1:0];
        end
      end
      trim_table();
    end else if (present && op == flr_pkg::OPC_SUCCESS) begin
      s = find_entry(key);
      if (s >= 0) begin
        t_valid[s] = 1'b0;
        t_count--;
      end
    end
    v.tracked = flr_pkg::CNT_BITS'(t_count);
    return v;
  endfunction

  always @(posedge clk) begin
    if (!rst && req_ch.valid && req_ch.ready) begin
      pending_verdicts.push_back(predict_verdict(req_ch.opcode, req_ch.key_present,
                                                 req_ch.source_key, req_ch.now_time));
      requests_sent++;
    end
  end

  always @(posedge clk) begin
    if (!rst && cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        flr_pkg::REG_SOURCE_LIMIT:  lim_sources  = cfg_ch.data[flr_pkg::CNT_BITS-1:0];
        flr_pkg::REG_FAILURE_LIMIT: lim_failures = cfg_ch.data[flr_pkg::FAIL_BITS-1:0];
        flr_pkg::REG_WINDOW_TICKS:  win_len      = cfg_ch.data[flr_pkg::TICK_BITS-1:0];
        flr_pkg::REG_BLOCK_TICKS:   block_len    = cfg_ch.data[flr_pkg::TICK_BITS-1:0];
        default: ;
      endcase
    end
  end

  always @(posedge clk) begin : check_results
    lockout_verdict_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      results_checked++;
      if (pending_verdicts.size() == 0) begin
        report_mismatch("result arrived with no request outstanding");
      end else begin
        want = pending_verdicts.pop_front();
        if (rsp_ch.allowed !== want.allowed || rsp_ch.tracked_count !== want.tracked)
          report_mismatch($sformatf("result %0d: allowed %b want %b, tracked_count %0d want %0d",
                                    results_checked, rsp_ch.allowed, want.allowed,
                                    rsp_ch.tracked_count, want.tracked));
      end
    end
  end

  always @(negedge clk) begin
    if (hold_off_request > 0) begin
      hold_left = hold_off_request;
      hold_off_request = 0;
    end
    if (hold_left > 0) begin
      rsp_ch.ready <= 1'b0;
      hold_left--;
    end else begin
      rsp_ch.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Watchdog: no handshake for %0d cycles", QUIET_LIMIT);
    $display("tb: failure");
    $finish;
  end

  task automatic send_item(input logic [1:0] op, input logic present,
                           input logic [flr_pkg::KEY_BITS-1:0] key,
                           input logic [flr_pkg::TIME_BITS-1:0] now);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.opcode      <= op;
    req_ch.key_present <= present;
    req_ch.source_key  <= key;
    req_ch.now_time    <= now;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_register(input logic [flr_pkg::CFG_IDX_BITS-1:0] idx,
                                input logic [flr_pkg::CFG_DATA_BITS-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_limits(input int unsigned sources, input int unsigned failures,
                            input logic [flr_pkg::TICK_BITS-1:0] window,
                            input logic [flr_pkg::TICK_BITS-1:0] block);
    wait_drained();
    write_register(flr_pkg::REG_SOURCE_LIMIT, flr_pkg::CFG_DATA_BITS'(sources));
    write_register(flr_pkg::REG_FAILURE_LIMIT, flr_pkg::CFG_DATA_BITS'(failures));
    write_register(flr_pkg::REG_WINDOW_TICKS, flr_pkg::CFG_DATA_BITS'(window));
    write_register(flr_pkg::REG_BLOCK_TICKS, flr_pkg::CFG_DATA_BITS'(block));
    cfg_ch.valid <= 1'b0;
    settings_applied++;
  endtask

  task automatic build_key_pool(input int n);
    key_pool.delete();
    for (int i = 0; i < n; i++) key_pool.push_back({$urandom, $urandom});
    key_pool[0] = KEY_ZERO;
    if (n > 2) key_pool[1] = KEY_ONES;
  endtask

  task automatic advance_clock(input int step_max);
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) begin
      // Same tick again, so that ties in the least recently seen scan occur.
    end else if (r < 88) begin
      tick_now += $urandom_range(1, step_max);
    end else if (r < 95) begin
      tick_now += $urandom_range(step_max, step_max * 40);
    end else begin
      tick_now -= $urandom_range(1, step_max * 4);
    end
  endtask

  task automatic run_random(input int n, input int step_max);
    int r;
    logic [1:0] op;
    logic present;
    logic [flr_pkg::KEY_BITS-1:0] key;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      present = 1'b1;
      key = key_pool[$urandom_range(0, key_pool.size() - 1)];
      if (r < 40) begin
        op = flr_pkg::OPC_QUERY;
      end else if (r < 80) begin
        op = flr_pkg::OPC_FAILURE;
      end else if (r < 92) begin
        op = flr_pkg::OPC_SUCCESS;
      end else if (r < 97) begin
        op = 2'($urandom_range(0, 2));
        present = 1'b0;
      end else begin
        op = OPC_UNUSED;
      end
      advance_clock(step_max);
      send_item(op, present, key, tick_now);
    end
  endtask

  task automatic test_default_rules();
    logic [flr_pkg::KEY_BITS-1:0] k_mid;
    k_mid = {$urandom, $urandom};
    send_idle_pct = 0;
    rsp_stall_pct = 0;
    send_item(flr_pkg::OPC_QUERY, 1'b1, KEY_ZERO, '0);
    send_item(flr_pkg::OPC_QUERY, 1'b0, k_mid, 48'd5);
    send_item(flr_pkg::OPC_FAILURE, 1'b0, k_mid, 48'd5);
    send_item(flr_pkg::OPC_SUCCESS, 1'b0, k_mid, 48'd5);
    send_item(OPC_UNUSED, 1'b1, KEY_ONES, TIME_MAX);
    for (int i = 0; i < 5; i++)
      send_item(flr_pkg::OPC_FAILURE, 1'b1, KEY_ONES,
                TIME_MAX - flr_pkg::TIME_BITS'(10 - i));
    send_item(flr_pkg::OPC_QUERY, 1'b1, KEY_ONES, TIME_MAX - 48'd1);
    send_item(flr_pkg::OPC_SUCCESS, 1'b1, KEY_ONES, '0);
    send_item(flr_pkg::OPC_QUERY, 1'b1, KEY_ONES, '0);
    send_item(flr_pkg::OPC_FAILURE, 1'b1, k_mid, 48'd1000);
    send_item(flr_pkg::OPC_FAILURE, 1'b1, k_mid, 48'd500);
    send_item(flr_pkg::OPC_QUERY, 1'b1, k_mid, 48'd400);
    send_item(flr_pkg::OPC_QUERY, 1'b1, k_mid, 48'd1060);
    send_item(flr_pkg::OPC_FAILURE, 1'b1, KEY_ZERO, '0);
  endtask

  task automatic test_clamped_limits();
    logic [flr_pkg::KEY_BITS-1:0] k_new;
    k_new = {$urandom, $urandom};
    set_limits(0, 0, '0, '0);
    send_item(flr_pkg::OPC_FAILURE, 1'b1, k_new, 48'd2000);
    send_item(flr_pkg::OPC_QUERY, 1'b1, k_new, 48'd2000);
    send_item(flr_pkg::OPC_QUERY, 1'b1, k_new, 48'd2001);
    send_item(flr_pkg::OPC_FAILURE, 1'b1, {$urandom, $urandom}, 48'd2005);
  endtask

  task automatic test_wide_limits();
    set_limits(31, 255, '1, '1);
    send_item(flr_pkg::OPC_FAILURE, 1'b1, KEY_ONES, TIME_MAX - 48'd2);
    send_item(flr_pkg::OPC_QUERY, 1'b1, KEY_ONES, TIME_MAX);
  endtask

  task automatic test_eviction_churn();
    set_limits(4, 3, 32'd50, 32'd100);
    send_idle_pct = 0;
    rsp_stall_pct = 0;
    build_key_pool(8);
    tick_now = '0;
    run_random(90, 8);
  endtask

  task automatic test_full_table();
    set_limits(16, 2, 32'd200, 32'd40);
    send_idle_pct = 81;
    rsp_stall_pct = 0;
    build_key_pool(24);
    tick_now = 48'd100;
    run_random(90, 6);
  endtask

  task automatic test_window_expiry();
    set_limits(7, 4, 32'd1000, 32'd30);
    send_idle_pct = 0;
    rsp_stall_pct = 81;
    build_key_pool(12);
    tick_now = {16'($urandom), $urandom};
    run_random(90, 100);
  endtask

  task automatic test_saturated_deadlines();
    set_limits(5, 2, '1, '1);
    send_idle_pct = 7;
    rsp_stall_pct = 7;
    build_key_pool(8);
    tick_now = TIME_MAX - flr_pkg::TIME_BITS'($urandom_range(0, 5000));
    run_random(60, 50);
  endtask

  task automatic test_backpressure();
    set_limits(3, 2, 32'd20, 32'd15);
    send_idle_pct = 0;
    rsp_stall_pct = 0;
    build_key_pool(6);
    tick_now = 48'd40;
    hold_off_request = HOLD_OFF_CYCLES;
    run_random(16, 5);
    wait_drained();
    rsp_stall_pct = 81;
    run_random(20, 5);
  endtask

  initial begin
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.opcode = flr_pkg::OPC_QUERY;
    req_ch.key_present = 1'b0;
    req_ch.source_key = '0;
    req_ch.now_time = '0;
    rsp_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = flr_pkg::REG_SOURCE_LIMIT;
    cfg_ch.data = '0;
    send_idle_pct = 0;
    rsp_stall_pct = 0;
    hold_off_request = 0;
    hold_left = 0;
    mismatch_count = 0;
    requests_sent = 0;
    results_checked = 0;
    settings_applied = 1;
    evictions = 0;
    refusals = 0;
    saturations = 0;
    tick_now = '0;
    clear_model();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_default_rules();
    test_clamped_limits();
    test_wide_limits();
    test_eviction_churn();
    test_full_table();
    test_window_expiry();
    test_saturated_deadlines();
    test_backpressure();

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_verdicts.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_verdicts.size()));

    $display("Covered %0d requests and %0d checked results under %0d limit settings.",
             requests_sent, results_checked, settings_applied);
    $display("Model saw %0d evictions, %0d blocked refusals, %0d saturated deadlines.",
             evictions, refusals, saturations);
    if (mismatch_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/flr_pkg.sv
hdl/flr_if.sv
hdl/flr_ctrl.sv
hdl/flr_datapath.sv
hdl/failure_lockout_rate_limiter.sv
hdl/flr_checker.sv
tb/sv/failure_lockout_rate_limiter_test.sv
